>>> rtl/rlts_pkg.sv
// rlts_pkg: shared types, constants and codes of the motor rl test sequencer
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps
`default_nettype none

package rlts_pkg;

    // sizing of the test run
    localparam int NUM_TESTS     = 4;
    localparam int WINDOW_CYCLES = 1024;  // power of two
    localparam int SAMPLE_W      = 16;

    // window counter counts up to WINDOW_CYCLES itself
    localparam int CNT_W     = $clog2(WINDOW_CYCLES + 1);
    localparam int ACC_START = 3 * WINDOW_CYCLES / 4;

    // squares of one axis pair, and their sum over a window
    localparam int SQ_W  = 2 * SAMPLE_W;
    localparam int MAG_W = SQ_W + 1;
    localparam int SUM_W = MAG_W + $clog2(WINDOW_CYCLES);

    // mean = sum * 4 / WINDOW_CYCLES
    localparam int MEAN_W     = 32;
    localparam int MEAN_SHIFT = $clog2(WINDOW_CYCLES) - 2;

    localparam int PHASE_W = 32;
    localparam int CFG_W   = 32;
    localparam int TEST_W  = 3;
    localparam int EXP_W   = 3;

    localparam logic [EXP_W-1:0] EXP_START = EXP_W'(2);
    localparam logic [EXP_W-1:0] EXP_MIN   = EXP_W'(1);
    localparam logic [EXP_W-1:0] EXP_MAX   = EXP_W'(5);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd2;

    localparam logic [CFG_W-1:0] START_STEP_RESET = 32'd170891318;
    localparam logic [CFG_W-1:0] HIGH_LIMIT_RESET = 32'd16777216;
    localparam logic [CFG_W-1:0] LOW_LIMIT_RESET  = 32'd671089;

    // stream widths
    localparam int S_DATA_W = 4 * SAMPLE_W;
    localparam int RES_W    = 1 + PHASE_W + EXP_W + TEST_W + 2 + 2 * MEAN_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_LOWERED  = 2'd1,
        VERDICT_RAISED   = 2'd2,
        VERDICT_ACCEPTED = 2'd3
    } verdict_t;

    // controls shared by both accumulator lanes
    typedef struct packed {
        logic clear;
        logic add;
    } lane_ctrl_t;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_sq_voltage;
        logic [MEAN_W-1:0]  mean_sq_current;
        verdict_t           verdict;
        logic [TEST_W-1:0]  test_number;
        logic [EXP_W-1:0]   drive_exponent;
        logic [PHASE_W-1:0] drive_phase;
        logic               drive_on;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/rlts_sq_lane.sv
// rlts_sq_lane: squared magnitude of one alpha-beta pair, window sum and mean
// depends on rlts_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlts_sq_lane
    import rlts_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_W-1:0] alpha,
    input  wire logic signed [SAMPLE_W-1:0] beta,
    output logic [MEAN_W-1:0]               mean
);

    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic signed [SQ_W-1:0]  alpha_sq;
    logic signed [SQ_W-1:0]  beta_sq;
    logic [MAG_W-1:0]        mag;
    logic [SUM_W+MEAN_W-1:0] scaled;

    assign alpha_sq = alpha * alpha;
    assign beta_sq  = beta * beta;
    assign mag      = {1'b0, alpha_sq} + {1'b0, beta_sq};

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.add)
        begin
            sum_next = sum_reg + SUM_W'(mag);
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // shift down to the mean, saturate to the mean width
    assign scaled = {{MEAN_W{1'b0}}, sum_reg} >> MEAN_SHIFT;
    assign mean   = (|scaled[SUM_W+MEAN_W-1:MEAN_W]) ? '1 : scaled[MEAN_W-1:0];

endmodule

`default_nettype wire

>>> rtl/rlts_seq.sv
// rlts_seq: test sequencer, merges lane means into the window verdict
// depends on rlts_pkg; drives the controls of both rlts_sq_lane copies
`timescale 1ns / 1ps
`default_nettype none

module rlts_seq
    import rlts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 step,
    input  wire logic                 cmd,
    input  wire logic [MEAN_W-1:0]    i_mean,
    input  wire logic [MEAN_W-1:0]    v_mean,
    output lane_ctrl_t                lane_ctrl,
    output result_t                   result
);

    logic [CFG_W-1:0]   start_step_reg;
    logic [CFG_W-1:0]   high_limit_reg;
    logic [CFG_W-1:0]   low_limit_reg;

    logic [CNT_W-1:0]   cycle_count_reg;
    logic [CNT_W-1:0]   cycle_count_next;
    logic [TEST_W-1:0]  test_index_reg;
    logic [TEST_W-1:0]  test_index_next;
    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] phase_acc_next;
    logic [PHASE_W-1:0] phase_step_reg;
    logic [PHASE_W-1:0] phase_step_next;
    logic [EXP_W-1:0]   volt_exp_reg;
    logic [EXP_W-1:0]   volt_exp_next;

    logic               running;
    logic               window_end;
    logic [PHASE_W-1:0] phase_base;
    verdict_t           verdict;
    logic [MEAN_W-1:0]  mi;
    logic [MEAN_W-1:0]  mv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg <= START_STEP_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
            low_limit_reg  <= LOW_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_STEP: start_step_reg <= cfg_data;
                CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign running    = (test_index_reg < TEST_W'(NUM_TESTS)) && (volt_exp_reg <= EXP_MAX);
    assign window_end = cycle_count_reg >= CNT_W'(WINDOW_CYCLES);

    always_comb
    begin
        cycle_count_next = cycle_count_reg;
        test_index_next  = test_index_reg;
        phase_acc_next   = phase_acc_reg;
        phase_step_next  = phase_step_reg;
        volt_exp_next    = volt_exp_reg;
        lane_ctrl        = '0;
        verdict          = VERDICT_NONE;
        mi               = '0;
        mv               = '0;
        phase_base       = phase_acc_reg;

        if (step)
        begin
            priority if (cmd)
            begin
                cycle_count_next = '0;
                test_index_next  = '0;
                phase_acc_next   = '0;
                phase_step_next  = start_step_reg;
                volt_exp_next    = EXP_START;
                lane_ctrl.clear  = 1'b1;
            end
            else if (running)
            begin
                if (window_end)
                begin
                    mi              = i_mean;
                    mv              = v_mean;
                    lane_ctrl.clear = 1'b1;
                    phase_base      = '0;
                    priority if (i_mean >= high_limit_reg && volt_exp_reg < EXP_MAX)
                    begin
                        volt_exp_next = volt_exp_reg + EXP_W'(1);
                        verdict       = VERDICT_LOWERED;
                    end
                    else if (i_mean < low_limit_reg && volt_exp_reg > EXP_MIN)
                    begin
                        volt_exp_next = volt_exp_reg - EXP_W'(1);
                        verdict       = VERDICT_RAISED;
                    end
                    else
                    begin
                        phase_step_next = phase_step_reg >> 1;
                        test_index_next = test_index_reg + TEST_W'(1);
                        verdict         = VERDICT_ACCEPTED;
                    end
                    cycle_count_next = CNT_W'(1);
                end
                else
                begin
                    lane_ctrl.add    = cycle_count_reg >= CNT_W'(ACC_START);
                    cycle_count_next = cycle_count_reg + CNT_W'(1);
                end
                phase_acc_next = phase_base + phase_step_next;
            end
            else
            begin
                // finished or idle: state holds
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg <= '0;
            test_index_reg  <= TEST_W'(NUM_TESTS);
            phase_acc_reg   <= '0;
            phase_step_reg  <= '0;
            volt_exp_reg    <= EXP_START;
        end
        else
        begin
            cycle_count_reg <= cycle_count_next;
            test_index_reg  <= test_index_next;
            phase_acc_reg   <= phase_acc_next;
            phase_step_reg  <= phase_step_next;
            volt_exp_reg    <= volt_exp_next;
        end
    end

    always_comb
    begin
        result.drive_on        = test_index_next < TEST_W'(NUM_TESTS);
        result.drive_phase     = phase_acc_next;
        result.drive_exponent  = volt_exp_next;
        result.test_number     = test_index_next;
        result.verdict         = verdict;
        result.mean_sq_current = mi;
        result.mean_sq_voltage = mv;
    end

`ifndef ASSERT_OFF
    a_test_range: assert property (@(posedge clk) disable iff (!rst_n)
        test_index_reg <= TEST_W'(NUM_TESTS))
        else $error("test index beyond run length");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        volt_exp_reg >= EXP_MIN && volt_exp_reg <= EXP_MAX)
        else $error("drive exponent out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cycle_count_reg <= CNT_W'(WINDOW_CYCLES))
        else $error("window counter overran");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && cmd |=> test_index_reg == '0 && phase_acc_reg == '0
                        && volt_exp_reg == EXP_START)
        else $error("start did not reinitialize the run");
`endif

endmodule

`default_nettype wire

>>> rtl/motor_rl_test_sequencer_top.sv
// motor_rl_test_sequencer_top: stream ports, output register, lanes and sequencer
// depends on rlts_pkg, rlts_sq_lane and rlts_seq
`timescale 1ns / 1ps
`default_nettype none

// Motor resistance/inductance test sequencer. Each input transfer is one PWM
// cycle (tuser = 0) or a start command (tuser = 1); every input transfer gives
// exactly one output transfer. One item is taken every clock while the output
// register is free or draining: the drive phase, window counter and two
// square-and-accumulate lanes (current and voltage) all update in the cycle
// the item is taken, and its result is captured in an output register by the
// same clock edge. The input stays ready while the output register is empty
// or is being drained in the same cycle. At the end of each window the
// lane sums are shifted to mean squares, compared against the two current
// limits and the exponent, test index and phase step updated. Reset leaves the
// block finished (test number four) until a start command; no clearing pass.
// Configuration writes take effect at the next clock and should be made while
// no transfer is outstanding.

module motor_rl_test_sequencer_top
    import rlts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration: 0 start_phase_step, 1 high_current_sq_limit,
    // 2 low_current_sq_limit
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // i_alpha, i_beta, v_alpha, v_beta
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [0:0]           s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // drive_on, drive_phase, drive_exponent, test_number, verdict,
    // mean_sq_current, mean_sq_voltage, zero fill
    output logic [M_DATA_W-1:0]       m_tdata
);

    logic       accept;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    result_t    res;
    lane_ctrl_t lane_ctrl;

    logic [MEAN_W-1:0] i_mean;
    logic [MEAN_W-1:0] v_mean;

    // input transfer whenever the output slot is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // current lane
    rlts_sq_lane u_i_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .alpha (s_tdata[SAMPLE_W-1:0]),
        .beta  (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .mean  (i_mean)
    );

    // voltage lane
    rlts_sq_lane u_v_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .alpha (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .beta  (s_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
        .mean  (v_mean)
    );

    // sequencer merges the lane means into the window verdict
    rlts_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .cmd       (s_tuser[0]),
        .i_mean    (i_mean),
        .v_mean    (v_mean),
        .lane_ctrl (lane_ctrl),
        .result    (res)
    );

    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    // struct packs drive_on in bit 0 up to mean_sq_voltage at the top
    assign m_tdata  = M_DATA_W'(out_res_reg);

endmodule

`default_nettype wire
